[rtl/wpps_pkg.sv]
package wpps_pkg;

  // field widths
  localparam int DATA_W    = 32;
  localparam int DT_W      = 17;
  localparam int MAXA_W    = 31;
  localparam int WPC_W     = 3;
  localparam int TGT_W     = 2;
  localparam int CFG_IDX_W = 3;

  // controller gains and arrival tolerances, all Q16.16
  localparam int KP_GAIN = 19661;
  localparam int KD_GAIN = 1966;
  localparam int POS_TOL = 656;
  localparam int VEL_TOL = 6554;

  // register reset values
  localparam logic [DT_W-1:0]   DT_RESET   = 17'd655;
  localparam logic [MAXA_W-1:0] MAXA_RESET = 31'd196608;
  localparam logic [WPC_W-1:0]  WPC_RESET  = 3'd1;

  // width of the intermediate sums fed to the saturation
  localparam int SAT_W = 52;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TIME  = 3'd0,
    CFG_ACCEL_BIAS = 3'd1,
    CFG_MAX_ACCEL  = 3'd2,
    CFG_WP_COUNT   = 3'd3,
    CFG_WP0        = 3'd4,
    CFG_WP1        = 3'd5,
    CFG_WP2        = 3'd6,
    CFG_WP3        = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    cfg_idx_t           index;
    logic [DATA_W-1:0]  data;
  } cfg_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] accel_noise;
    logic signed [DATA_W-1:0] pos_noise;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
    logic [DATA_W-1:0]        elapsed;
    logic signed [DATA_W-1:0] est_position;
    logic signed [DATA_W-1:0] est_velocity;
    logic signed [DATA_W-1:0] accel_cmd;
    logic signed [DATA_W-1:0] measured_position;
    logic [TGT_W-1:0]         target_index;
  } out_req_t;

  // clip a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(33'sh0_7FFF_FFFF);
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      return DATA_W'(hi);
    end else if (v < lo) begin
      return DATA_W'(lo);
    end
    return DATA_W'(v);
  endfunction

endpackage

[rtl/wpps_chan_if.sv]
interface wpps_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/waypoint_pd_plant_step_top.sv]
// One Euler step of a PD-steered double integrator per input request: the target
// waypoint advances cyclically once the plant has settled on it, the commanded
// acceleration 0.3*error - 0.03*velocity/dt is clamped to +-max_accel, and true
// state, dead-reckoned estimate, elapsed time and a noisy position reading are
// returned as one result request, all in saturating Q16.16. One shared 33x18
// signed multiplier does all six products in turn, and the velocity/dt term is
// divided two quotient bits per cycle. The input is ready only while the
// sequencer is idle; a finished result sits in an output register, so the next
// request may be accepted before the previous result is taken. Configuration
// writes are always accepted and must only be issued while the block is idle.
module waypoint_pd_plant_step_top #(
  parameter int NUM_WAYPOINTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  wpps_chan_if.sink   in_if,
  wpps_chan_if.source out_if,
  wpps_chan_if.sink   cfg_if
);

  localparam int DATA_W    = wpps_pkg::DATA_W;
  localparam int DT_W      = wpps_pkg::DT_W;
  localparam int MAXA_W    = wpps_pkg::MAXA_W;
  localparam int WPC_W     = wpps_pkg::WPC_W;
  localparam int TGT_W     = wpps_pkg::TGT_W;
  localparam int SAT_W     = wpps_pkg::SAT_W;
  localparam int WP_DEPTH  = (NUM_WAYPOINTS < 2) ? 2 : NUM_WAYPOINTS;
  localparam int IDX_W     = $clog2(WP_DEPTH);
  localparam int CNT_W     = $clog2(NUM_WAYPOINTS + 1);
  localparam int MUL_A_W   = DATA_W + 1;
  localparam int MUL_B_W   = DT_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SH_W      = PROD_W - 16;
  localparam int DIVD_W    = 42;
  localparam int DIV_STEP  = 2;
  localparam int DIV_CYC   = DIVD_W / DIV_STEP;
  localparam int DCNT_W    = $clog2(DIV_CYC);
  localparam int ACC_W     = DIVD_W + 2;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_CHK  = 12'b0000_0000_0010,
    ST_KP   = 12'b0000_0000_0100,
    ST_KD   = 12'b0000_0000_1000,
    ST_DSET = 12'b0000_0001_0000,
    ST_DIV  = 12'b0000_0010_0000,
    ST_ACC  = 12'b0000_0100_0000,
    ST_VEL  = 12'b0000_1000_0000,
    ST_VUPD = 12'b0001_0000_0000,
    ST_EV   = 12'b0010_0000_0000,
    ST_EP   = 12'b0100_0000_0000,
    ST_OUT  = 12'b1000_0000_0000
  } state_t;

  // configuration registers
  logic [DT_W-1:0]          dt_r;
  logic signed [DATA_W-1:0] bias_r;
  logic [MAXA_W-1:0]        maxa_r;
  logic [WPC_W-1:0]         wpc_r;
  logic signed [DATA_W-1:0] wp_r [WP_DEPTH];

  // plant and estimator state
  logic signed [DATA_W-1:0] pos_r;
  logic signed [DATA_W-1:0] vel_r;
  logic [DATA_W-1:0]        time_r;
  logic signed [DATA_W-1:0] epos_r;
  logic signed [DATA_W-1:0] evel_r;
  logic [IDX_W-1:0]         idx_r;

  // sequencer and working registers
  state_t                   state_r;
  state_t                   state_nxt;
  logic signed [DATA_W-1:0] noise_a_r;
  logic signed [DATA_W-1:0] noise_p_r;
  logic signed [PROD_W-1:0] mul_r;
  logic signed [DATA_W-1:0] kpt_r;
  logic [DIVD_W-1:0]        dq_r;
  logic [DT_W-1:0]          rem_r;
  logic                     dneg_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic signed [DATA_W-1:0] acc_r;
  logic signed [DATA_W-1:0] ahat_r;

  // result register
  logic                     out_valid_r;
  wpps_pkg::out_req_t       out_data_r;

  logic                     in_fire;
  logic                     cfg_fire;
  logic                     out_load;
  logic [DT_W-1:0]          dt_eff;
  logic [CNT_W-1:0]         cnt_eff;
  logic signed [DATA_W-1:0] wp_cur;
  logic signed [MUL_A_W-1:0] err;
  logic [MUL_A_W-1:0]       err_abs;
  logic [DATA_W-1:0]        vel_abs;
  logic                     settled;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_B_W-1:0] dt_s;
  logic signed [SH_W-1:0]   mul_sh;
  logic [PROD_W-1:0]        prod_mag;
  logic [DIVD_W-1:0]        dq_nxt;
  logic [DT_W-1:0]          rem_nxt;
  logic signed [ACC_W-1:0]  quot_s;
  logic signed [ACC_W-1:0]  acc_full;
  logic signed [ACC_W-1:0]  lim_s;
  logic signed [DATA_W-1:0] acc_clamped;
  logic [DATA_W:0]          time_sum;
  logic [1:0]               wp_slot;

  assign in_fire  = in_if.valid && in_if.ready;
  assign cfg_fire = cfg_if.valid && cfg_if.ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_if.ready);

  assign in_if.ready   = (state_r == ST_IDLE);
  assign cfg_if.ready  = 1'b1;
  assign out_if.valid  = out_valid_r;
  assign out_if.payload = out_data_r;

  // zero step time behaves as the smallest step
  assign dt_eff = (dt_r == '0) ? DT_W'(1) : dt_r;
  assign dt_s   = signed'({1'b0, dt_eff});

  // waypoint count limited to 1..NUM_WAYPOINTS
  always_comb begin
    if (wpc_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (int'(wpc_r) > NUM_WAYPOINTS) begin
      cnt_eff = CNT_W'(NUM_WAYPOINTS);
    end else begin
      cnt_eff = CNT_W'(wpc_r);
    end
  end

  // arrival test against the current waypoint
  assign wp_cur  = wp_r[idx_r];
  assign err     = MUL_A_W'(wp_cur) - MUL_A_W'(pos_r);
  assign err_abs = err[MUL_A_W-1] ? MUL_A_W'(-err) : MUL_A_W'(err);
  assign vel_abs = vel_r[DATA_W-1] ? DATA_W'(-vel_r) : DATA_W'(vel_r);
  assign settled = (err_abs < MUL_A_W'(wpps_pkg::POS_TOL))
                && (vel_abs < DATA_W'(wpps_pkg::VEL_TOL));

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_KP: begin
        mul_a = err;
        mul_b = MUL_B_W'(wpps_pkg::KP_GAIN);
      end
      ST_KD: begin
        mul_a = MUL_A_W'(vel_r);
        mul_b = MUL_B_W'(wpps_pkg::KD_GAIN);
      end
      ST_ACC: begin
        mul_a = MUL_A_W'(vel_r);
        mul_b = dt_s;
      end
      ST_VEL: begin
        mul_a = MUL_A_W'(acc_r);
        mul_b = dt_s;
      end
      ST_VUPD: begin
        mul_a = MUL_A_W'(ahat_r);
        mul_b = dt_s;
      end
      ST_EV: begin
        mul_a = MUL_A_W'(evel_r);
        mul_b = dt_s;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product scaled back to Q16.16, rounding toward minus infinity
  assign mul_sh   = SH_W'(mul_r >>> 16);
  assign prod_mag = mul_r[PROD_W-1] ? PROD_W'(-mul_r) : PROD_W'(mul_r);

  // two restoring division steps per cycle
  always_comb begin
    logic [DT_W:0] trial;
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial  = {rem_nxt, dq_nxt[DIVD_W-1]};
      dq_nxt = {dq_nxt[DIVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dt_eff}) begin
        trial     = trial - {1'b0, dt_eff};
        dq_nxt[0] = 1'b1;
      end
      rem_nxt = DT_W'(trial);
    end
  end

  // acceleration command and clamp
  always_comb begin
    quot_s   = signed'(ACC_W'(dq_r));
    if (dneg_r) begin
      quot_s = -quot_s;
    end
    acc_full = ACC_W'(kpt_r) - quot_s;
    lim_s    = signed'(ACC_W'(maxa_r));
    if (acc_full > lim_s) begin
      acc_clamped = DATA_W'(lim_s);
    end else if (acc_full < -lim_s) begin
      acc_clamped = DATA_W'(-lim_s);
    end else begin
      acc_clamped = DATA_W'(acc_full);
    end
  end

  assign time_sum = {1'b0, time_r} + (DATA_W + 1)'(dt_eff);
  assign wp_slot  = 2'(cfg_if.payload.index - wpps_pkg::CFG_WP0);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_CHK;
      ST_CHK:  state_nxt = ST_KP;
      ST_KP:   state_nxt = ST_KD;
      ST_KD:   state_nxt = ST_DSET;
      ST_DSET: state_nxt = ST_DIV;
      ST_DIV:  if (dcnt_r == DCNT_W'(DIV_CYC - 1)) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_VEL;
      ST_VEL:  state_nxt = ST_VUPD;
      ST_VUPD: state_nxt = ST_EV;
      ST_EV:   state_nxt = ST_EP;
      ST_EP:   state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration, plant state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dt_r        <= wpps_pkg::DT_RESET;
      bias_r      <= '0;
      maxa_r      <= wpps_pkg::MAXA_RESET;
      wpc_r       <= wpps_pkg::WPC_RESET;
      for (int i = 0; i < WP_DEPTH; i++) begin
        wp_r[i] <= '0;
      end
      pos_r       <= '0;
      vel_r       <= '0;
      time_r      <= '0;
      epos_r      <= '0;
      evel_r      <= '0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_fire) begin
        unique case (cfg_if.payload.index)
          wpps_pkg::CFG_STEP_TIME:  dt_r   <= cfg_if.payload.data[DT_W-1:0];
          wpps_pkg::CFG_ACCEL_BIAS: bias_r <= signed'(cfg_if.payload.data);
          wpps_pkg::CFG_MAX_ACCEL:  maxa_r <= cfg_if.payload.data[MAXA_W-1:0];
          wpps_pkg::CFG_WP_COUNT:   wpc_r  <= cfg_if.payload.data[WPC_W-1:0];
          wpps_pkg::CFG_WP0, wpps_pkg::CFG_WP1,
          wpps_pkg::CFG_WP2, wpps_pkg::CFG_WP3: begin
            if (int'(wp_slot) < NUM_WAYPOINTS) begin
              wp_r[IDX_W'(wp_slot)] <= signed'(cfg_if.payload.data);
            end
          end
          default: ;
        endcase
      end

      // index left beyond a lowered count restarts at the first waypoint
      if (in_fire && (int'(idx_r) >= int'(cnt_eff))) begin
        idx_r <= '0;
      end

      // advance cyclically once settled on the target
      if (state_r == ST_CHK && settled) begin
        if (int'(idx_r) + 1 >= int'(cnt_eff)) begin
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end

      if (state_r == ST_VEL) begin
        pos_r <= wpps_pkg::sat_s32(SAT_W'(pos_r) + SAT_W'(mul_sh));
      end
      if (state_r == ST_VUPD) begin
        vel_r <= wpps_pkg::sat_s32(SAT_W'(vel_r) + SAT_W'(mul_sh));
      end
      if (state_r == ST_EV) begin
        evel_r <= wpps_pkg::sat_s32(SAT_W'(evel_r) + SAT_W'(mul_sh));
      end
      if (state_r == ST_EP) begin
        epos_r <= wpps_pkg::sat_s32(SAT_W'(epos_r) + SAT_W'(mul_sh));
        time_r <= time_sum[DATA_W] ? '1 : time_sum[DATA_W-1:0];
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;

    if (in_fire) begin
      noise_a_r <= in_if.payload.accel_noise;
      noise_p_r <= in_if.payload.pos_noise;
    end

    if (state_r == ST_KD) begin
      kpt_r <= DATA_W'(mul_sh);
    end

    // divider load with magnitude of the damping product
    if (state_r == ST_DSET) begin
      dq_r   <= DIVD_W'(prod_mag);
      rem_r  <= '0;
      dneg_r <= mul_r[PROD_W-1];
      dcnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      dq_r   <= dq_nxt;
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end

    if (state_r == ST_ACC) begin
      acc_r <= acc_clamped;
    end

    // estimated acceleration from command, noise and bias
    if (state_r == ST_VEL) begin
      ahat_r <= wpps_pkg::sat_s32(SAT_W'(acc_r) + SAT_W'(noise_a_r) - SAT_W'(bias_r));
    end

    if (out_load) begin
      out_data_r.position          <= pos_r;
      out_data_r.velocity          <= vel_r;
      out_data_r.elapsed           <= time_r;
      out_data_r.est_position      <= epos_r;
      out_data_r.est_velocity      <= evel_r;
      out_data_r.accel_cmd         <= acc_r;
      out_data_r.measured_position <= wpps_pkg::sat_s32(SAT_W'(pos_r) + SAT_W'(noise_p_r));
      out_data_r.target_index      <= TGT_W'(idx_r);
    end
  end

endmodule
